[rtl/core/hda_pkg.sv]
// Shared types and constants for the hundredths to decimal ASCII printer.
// Used by every module under rtl/core; depends on nothing else.
`default_nettype none

package hda_pkg;

	// One 6-bit ASCII character and one decimal digit.
	typedef logic [5:0] char_t;
	typedef logic [3:0] digit_t;

	// Most characters one value can produce.
	localparam int unsigned MAX_CHARS = 6;
	localparam int unsigned COUNT_W   = 3;

	// ASCII codes, already cut to six bits.
	localparam char_t ASCII_ZERO  = 6'd48;
	localparam char_t ASCII_POINT = 6'd46;

	// value / 100 is (value * RECIP100) >> RECIP100_SHIFT, exact for all 16-bit values.
	localparam logic [16:0] RECIP100       = 17'd83887;
	localparam int unsigned RECIP100_SHIFT = 23;

	// Intermediate results handed from the divider to the digit stage.
	typedef struct packed {
		logic [15:0] value;
		logic [9:0]  whole;
	} split_t;

	// A finished line of text: characters in send order, slot 0 first.
	typedef struct packed {
		char_t [MAX_CHARS-1:0]  chars;
		logic  [COUNT_W-1:0]    count;
	} text_t;

	// A decimal digit as its ASCII character; '0' is 6'b110000.
	function automatic char_t digit_char(input digit_t d);
		return {2'b11, d};
	endfunction

endpackage

`default_nettype wire

[rtl/core/hda_divide.sv]
// Input register and the divide-by-100 stage of the decimal printer.
// Depends on hda_pkg.
`default_nettype none

module hda_divide
	import hda_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        up_valid,
	output logic             up_ready,
	input  wire logic [15:0] up_value,
	output logic             dn_valid,
	input  wire logic        dn_ready,
	output split_t           dn_split
);

	logic        valid_s1;
	logic [15:0] value_s1;
	logic        valid_s2;
	split_t      split_s2;
	logic        ready_s1;
	logic        ready_s2;
	logic [32:0] prod;

	// A stage can take a beat when it is empty or its content moves on.
	assign ready_s2 = !valid_s2 || dn_ready;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign up_ready = ready_s1;

	// Reciprocal multiply gives the integer part.
	assign prod = 33'(value_s1) * 33'(RECIP100);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (ready_s1) begin
				valid_s1 <= up_valid;
			end
			if (ready_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	// Payload registers load only when a beat enters the stage.
	always_ff @(posedge clk) begin
		if (up_valid && ready_s1) begin
			value_s1 <= up_value;
		end
		if (valid_s1 && ready_s2) begin
			split_s2.value <= value_s1;
			split_s2.whole <= prod[RECIP100_SHIFT +: 10];
		end
	end

	assign dn_valid = valid_s2;
	assign dn_split = split_s2;

endmodule

`default_nettype wire

[rtl/core/hda_digits.sv]
// Digit extraction and text assembly for the decimal printer.
// Depends on hda_pkg.
`default_nettype none

module hda_digits
	import hda_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   up_valid,
	output logic        up_ready,
	input  wire split_t up_split,
	output logic        dn_valid,
	input  wire logic   dn_ready,
	output text_t       dn_text
);

	logic        valid_s3;
	logic [6:0]  frac_s3;
	logic [6:0]  q10_s3;
	digit_t      hund_s3;
	logic [9:0]  whole_s3;
	logic        ready_s3;

	logic [15:0] whole_x100;
	logic [15:0] frac_wide;
	logic [17:0] q10_prod;
	logic [15:0] hund_prod;

	logic [6:0]  hund_x10;
	logic [9:0]  q10_x10;
	logic [14:0] f1_prod;
	digit_t      tens;
	digit_t      ones;
	digit_t      frac_hi;
	digit_t      frac_lo;
	logic [6:0]  frac_hi_x10;
	char_t       point;

	assign ready_s3 = !valid_s3 || dn_ready;
	assign up_ready = ready_s3;

	// Fraction and the tens and hundreds quotients of the integer part.
	assign whole_x100 = 16'(up_split.whole) * 16'd100;
	assign frac_wide  = up_split.value - whole_x100;
	assign q10_prod   = 18'(up_split.whole) * 18'd205;
	assign hund_prod  = 16'(up_split.whole) * 16'd41;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (ready_s3) begin
			valid_s3 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_valid && ready_s3) begin
			frac_s3  <= frac_wide[6:0];
			q10_s3   <= q10_prod[17:11];
			hund_s3  <= hund_prod[15:12];
			whole_s3 <= up_split.whole;
		end
	end

	// Remaining digits by subtracting ten times the next quotient.
	assign hund_x10    = 7'(hund_s3) * 7'd10;
	assign q10_x10     = 10'(q10_s3) * 10'd10;
	assign tens        = digit_t'(q10_s3 - hund_x10);
	assign ones        = digit_t'(whole_s3 - q10_x10);
	assign f1_prod     = 15'(frac_s3) * 15'd205;
	assign frac_hi     = f1_prod[14:11];
	assign frac_hi_x10 = 7'(frac_hi) * 7'd10;
	assign frac_lo     = digit_t'(frac_s3 - frac_hi_x10);
	assign point       = ASCII_POINT;

	// Place the characters; leading zeros of the integer part are dropped.
	always_comb begin
		dn_text.chars = {MAX_CHARS{point}};
		if (hund_s3 != 4'd0) begin
			dn_text.chars[0] = digit_char(hund_s3);
			dn_text.chars[1] = digit_char(tens);
			dn_text.chars[2] = digit_char(ones);
			dn_text.chars[3] = ASCII_POINT;
			dn_text.chars[4] = digit_char(frac_hi);
			dn_text.chars[5] = digit_char(frac_lo);
			dn_text.count    = 3'd6;
		end else if (tens != 4'd0) begin
			dn_text.chars[0] = digit_char(tens);
			dn_text.chars[1] = digit_char(ones);
			dn_text.chars[2] = ASCII_POINT;
			dn_text.chars[3] = digit_char(frac_hi);
			dn_text.chars[4] = digit_char(frac_lo);
			dn_text.count    = 3'd5;
		end else begin
			dn_text.chars[0] = digit_char(ones);
			dn_text.chars[1] = ASCII_POINT;
			dn_text.chars[2] = digit_char(frac_hi);
			dn_text.chars[3] = digit_char(frac_lo);
			dn_text.count    = 3'd4;
		end
	end

	assign dn_valid = valid_s3;

endmodule

`default_nettype wire

[rtl/core/hda_serial.sv]
// Character buffer that sends one assembled line one character per beat.
// Depends on hda_pkg.
`default_nettype none

module hda_serial
	import hda_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  up_valid,
	output logic       up_ready,
	input  wire text_t up_text,
	output logic       dn_valid,
	input  wire logic  dn_ready,
	output char_t      dn_char,
	output logic       dn_last
);

	char_t [MAX_CHARS-1:0] chars_q;
	logic  [COUNT_W-1:0]   left_q;
	logic                  take;
	logic                  load;

	// A new line may load as the final character of the current one leaves.
	assign dn_valid = (left_q != '0);
	assign take     = dn_valid && dn_ready;
	assign up_ready = !dn_valid || (take && left_q == COUNT_W'(1));
	assign load     = up_valid && up_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q <= '0;
		end else if (load) begin
			left_q <= up_text.count;
		end else if (take) begin
			left_q <= left_q - COUNT_W'(1);
		end
	end

	// Shift the line toward slot 0 as characters are taken.
	always_ff @(posedge clk) begin
		if (load) begin
			chars_q <= up_text.chars;
		end else if (take) begin
			for (int i = 0; i < MAX_CHARS - 1; i++) begin
				chars_q[i] <= chars_q[i+1];
			end
		end
	end

	assign dn_char = chars_q[0];
	assign dn_last = (left_q == COUNT_W'(1));

endmodule

`default_nettype wire

[rtl/core/hundredths_to_decimal_ascii_top.sv]
// Top level of the hundredths to decimal ASCII printer.
// Depends on hda_pkg, hda_divide, hda_digits and hda_serial.
//
// Each accepted 16-bit value in hundredths comes out as ASCII text such as
// "655.35" or "0.05", one character per beat, with last high on the final
// character. The integer part has no leading zeros but always at least one
// digit, and both fraction digits are always sent. A value yields four to
// six characters; the character buffer drains one character a cycle while
// char_ready is high. A value passes from the input register through the
// divide, digit and character buffer registers before its first character
// appears. Values are taken back to back into the pipeline while earlier
// text is still being sent, until its registers fill.
`default_nettype none

module hundredths_to_decimal_ascii_top
	import hda_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        item_valid,
	output logic             item_ready,
	input  wire logic [15:0] value,
	output logic             char_valid,
	input  wire logic        char_ready,
	output logic [5:0]       ascii_char,
	output logic             last
);

	logic   split_valid;
	logic   split_ready;
	split_t split;
	logic   text_valid;
	logic   text_ready;
	text_t  text;

	// Input register and divide by 100.
	hda_divide u_divide (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (item_valid),
		.up_ready (item_ready),
		.up_value (value),
		.dn_valid (split_valid),
		.dn_ready (split_ready),
		.dn_split (split)
	);

	// Digits and text assembly.
	hda_digits u_digits (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (split_valid),
		.up_ready (split_ready),
		.up_split (split),
		.dn_valid (text_valid),
		.dn_ready (text_ready),
		.dn_text  (text)
	);

	// One character per beat out of the buffer.
	hda_serial u_serial (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (text_valid),
		.up_ready (text_ready),
		.up_text  (text),
		.dn_valid (char_valid),
		.dn_ready (char_ready),
		.dn_char  (ascii_char),
		.dn_last  (last)
	);

endmodule

`default_nettype wire
